>>> hw/rtl/fbcks_pkg.sv
// Shared types and constants for the keyed-table Feistel cipher.
// No dependencies.
`default_nettype none
package fbcks_pkg;
    localparam int BLOCK_W = 64;
    localparam int HALF_W  = 32;
    localparam int KEY_BYTES = 32;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY0 = 2'd0,
        CFG_KEY1 = 2'd1,
        CFG_KEY2 = 2'd2,
        CFG_KEY3 = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KLOAD,
        ST_KSHIFT,
        ST_KSUM,
        ST_INIT,
        ST_SW_RI,
        ST_SW_RJ,
        ST_SW_RN,
        ST_SW_WI,
        ST_SW_WJ,
        ST_RD,
        ST_RD_WAIT,
        ST_MIX,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic key_load;
        logic key_shift;
        logic sum_step;
        logic init_write;
        logic sw_read_i;
        logic sw_read_j;
        logic sw_read_n;
        logic sw_write_i;
        logic sw_write_j;
        logic blk_load;
        logic rd_issue;
        logic rd_capture;
        logic round_mix;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic cnt_last;
        logic tab_last;
        logic byte_last;
    } t_sts;
endpackage
`default_nettype wire

>>> hw/rtl/fbcks_dp.sv
// Datapath: key copy, table memory, swap walk and round logic.
// Depends on fbcks_pkg.
`default_nettype none
module fbcks_dp
    import fbcks_pkg::*;
#(
    parameter int ROUND_COUNT = 16
) (
    input  wire logic               i_clk,
    input  wire t_cmd               i_cmd,
    output t_sts                    o_sts,
    input  wire logic [4*BLOCK_W-1:0] i_key,
    input  wire logic               i_op,
    input  wire logic [BLOCK_W-1:0] i_block,
    output logic [BLOCK_W-1:0]      o_block
);
    localparam int TW = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;
    localparam int AW = TW + 8;

    logic [7:0]        r_wk [KEY_BYTES];
    logic [7:0]        r_mem [ROUND_COUNT*256];
    logic [7:0]        r_rdata;
    logic [TW-1:0]     r_tab;
    logic [8:0]        r_cnt;
    logic [7:0]        r_j, r_ti, r_x;
    logic [1:0]        r_byte;
    logic              r_op;
    logic [HALF_W-1:0] r_l, r_r, r_f;

    logic [AW-1:0] w_addr;
    logic          w_we;
    logic [7:0]    w_wdata, w_jn;
    logic [TW-1:0] w_rt;
    logic [HALF_W-1:0] w_h;
    logic [7:0]    w_hb;
    logic [4:0]    w_k;

    assign w_k  = 5'(r_ti + r_rdata);
    assign w_jn = r_j + r_wk[w_k];
    assign w_rt = r_op ? TW'(ROUND_COUNT - 1) - r_tab : r_tab;
    assign w_h  = r_op ? r_l : r_r;
    always_comb begin
        unique case (r_byte)
            2'd0: w_hb = w_h[31:24];
            2'd1: w_hb = w_h[23:16];
            2'd2: w_hb = w_h[15:8];
            default: w_hb = w_h[7:0];
        endcase
    end

    always_comb begin
        w_we = 1'b0;
        w_wdata = r_ti;
        w_addr = {r_tab, r_cnt[7:0]};
        if (i_cmd.init_write) begin
            w_we = 1'b1;
            w_wdata = r_cnt[7:0];
        end else if (i_cmd.sw_read_j) begin
            w_addr = {r_tab, r_j};
        end else if (i_cmd.sw_read_n) begin
            w_addr = {r_tab, w_jn};
        end else if (i_cmd.sw_write_i) begin
            w_we = 1'b1;
            w_wdata = r_rdata;
        end else if (i_cmd.sw_write_j) begin
            w_we = 1'b1;
            w_wdata = r_ti;
            w_addr = {r_tab, r_j};
        end else if (i_cmd.rd_issue) begin
            w_addr = {w_rt, (r_byte == 2'd0) ? w_hb : r_x + w_hb};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_addr] <= w_wdata;
        end
        r_rdata <= r_mem[w_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.key_load) begin
            for (int i = 0; i < KEY_BYTES; i++) begin
                r_wk[i] <= i_key[4*BLOCK_W-1-8*i -: 8];
            end
            r_tab <= '0;
        end
        if (i_cmd.key_shift) begin
            for (int i = 0; i < KEY_BYTES-1; i++) begin
                r_wk[i] <= r_wk[i+1] ^ 8'(r_tab);
            end
        end
        if (i_cmd.key_load || i_cmd.key_shift) begin
            r_cnt <= '0;
            r_j <= '0;
        end
        if (i_cmd.sum_step) begin
            r_j <= r_j + r_wk[r_cnt[4:0]];
            r_cnt <= (r_cnt[4:0] == 5'd31) ? 9'd0 : r_cnt + 9'd1;
        end
        if (i_cmd.init_write) begin
            r_cnt <= (r_cnt[7:0] == 8'd255) ? 9'd0 : r_cnt + 9'd1;
        end
        if (i_cmd.sw_read_j) begin
            r_ti <= r_rdata;
        end
        if (i_cmd.sw_read_n) begin
            r_j <= w_jn;
        end
        if (i_cmd.sw_write_j) begin
            r_cnt <= r_cnt + 9'd1;
            if (r_cnt[7:0] == 8'd255) begin
                r_tab <= o_sts.tab_last ? '0 : r_tab + TW'(1);
            end
        end
        if (i_cmd.blk_load) begin
            r_op <= i_op;
            r_l <= i_block[63:32];
            r_r <= i_block[31:0];
            r_tab <= '0;
            r_byte <= '0;
            r_x <= '0;
        end
        if (i_cmd.rd_issue) begin
            r_x <= (r_byte == 2'd0) ? w_hb : r_x + w_hb;
        end
        if (i_cmd.rd_capture) begin
            r_f <= {r_rdata, r_f[31:8]};
            r_byte <= r_byte + 2'd1;
        end
        if (i_cmd.round_mix) begin
            if (r_op) begin
                r_l <= r_r ^ r_f;
                r_r <= r_l;
            end else begin
                r_l <= r_r;
                r_r <= r_l ^ r_f;
            end
            r_tab <= r_tab + TW'(1);
        end
        if (i_cmd.out_load) begin
            o_block <= {r_l, r_r};
        end
    end

    always_comb begin
        o_sts.byte_last = (r_byte == 2'd3);
        o_sts.tab_last  = (r_tab == TW'(ROUND_COUNT - 1));
        o_sts.cnt_last  = i_cmd.sum_step ? (r_cnt[4:0] == 5'd31) : (r_cnt[7:0] == 8'd255);
    end
endmodule
`default_nettype wire

>>> hw/rtl/fbcks_ctrl.sv
// Controller: table build sequence once after reset, then round sequence.
// Depends on fbcks_pkg.
`default_nettype none
module fbcks_ctrl
    import fbcks_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    output logic      o_valid,
    input  wire logic i_stall,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);
    t_state r_state, n_state;
    logic   r_ready, n_ready;
    logic   r_ovalid;
    logic   w_acc;

    assign o_stall = (r_state != ST_IDLE);
    assign w_acc   = i_valid && !o_stall;
    assign o_valid = r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ready <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= n_ready;
            if (o_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_ready = r_ready;
        unique case (r_state)
            ST_IDLE:    if (w_acc) n_state = r_ready ? ST_RD : ST_KLOAD;
            ST_KLOAD:   n_state = ST_KSUM;
            ST_KSHIFT:  n_state = ST_KSUM;
            ST_KSUM:    if (i_sts.cnt_last) n_state = ST_INIT;
            ST_INIT:    if (i_sts.cnt_last) n_state = ST_SW_RI;
            ST_SW_RI:   n_state = ST_SW_RJ;
            ST_SW_RJ:   n_state = ST_SW_RN;
            ST_SW_RN:   n_state = ST_SW_WI;
            ST_SW_WI:   n_state = ST_SW_WJ;
            ST_SW_WJ: begin
                if (!i_sts.cnt_last) begin
                    n_state = ST_SW_RI;
                end else if (i_sts.tab_last) begin
                    n_state = ST_RD;
                    n_ready = 1'b1;
                end else begin
                    n_state = ST_KSHIFT;
                end
            end
            ST_RD:      n_state = ST_RD_WAIT;
            ST_RD_WAIT: n_state = i_sts.byte_last ? ST_MIX : ST_RD;
            ST_MIX:     n_state = i_sts.tab_last ? ST_DONE : ST_RD;
            ST_DONE:    if (!(r_ovalid && i_stall)) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.blk_load = w_acc;
        o_cmd.key_load = (r_state == ST_KLOAD);
        o_cmd.key_shift = (r_state == ST_KSHIFT);
        o_cmd.sum_step = (r_state == ST_KSUM);
        o_cmd.init_write = (r_state == ST_INIT);
        o_cmd.sw_read_i = (r_state == ST_SW_RI);
        o_cmd.sw_read_j = (r_state == ST_SW_RJ);
        o_cmd.sw_read_n = (r_state == ST_SW_RN);
        o_cmd.sw_write_i = (r_state == ST_SW_WI);
        o_cmd.sw_write_j = (r_state == ST_SW_WJ);
        o_cmd.rd_issue = (r_state == ST_RD);
        o_cmd.rd_capture = (r_state == ST_RD_WAIT);
        o_cmd.round_mix = (r_state == ST_MIX);
        o_cmd.out_load = (r_state == ST_DONE) && !(r_ovalid && i_stall);
    end

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> o_valid) else $error("result lost");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> o_stall) else $error("accepted while busy");
    a_ready_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ready |=> r_ready) else $error("tables ready dropped");
endmodule
`default_nettype wire

>>> hw/rtl/feistel_block_cipher_keyed_sboxes_top.sv
// Top level: key registers, controller and datapath.
// Depends on fbcks_pkg, fbcks_ctrl, fbcks_dp.
//
// channel | direction | handshake         | payload
// cfg     | in        | valid / ready     | i_cfg_index, i_cfg_data
// in      | in        | i_valid / o_stall | i_op, i_block_in
// out     | out       | o_valid / i_stall | o_block_out
//
// Each block runs 16 rounds (ROUND_COUNT): four table reads, each issued then captured
// through the single table memory port, then the mix. The first block after reset first builds
// the tables: per table a key load or shift, a key sum, an init of 256 entries, then a swap
// walk over 256 entries. Reset is synchronous, active low. A stalled result holds the result
// register and the controller, so the input stalls until that result transfers.
`default_nettype none
module feistel_block_cipher_keyed_sboxes_top
    import fbcks_pkg::*;
#(
    parameter int ROUND_COUNT = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [BLOCK_W-1:0]   i_cfg_data,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic                 i_op,
    input  wire logic [BLOCK_W-1:0]   i_block_in,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic [BLOCK_W-1:0]        o_block_out
);
    logic [BLOCK_W-1:0] r_key [4];
    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) r_key[i] <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_KEY0: r_key[0] <= i_cfg_data;
                CFG_KEY1: r_key[1] <= i_cfg_data;
                CFG_KEY2: r_key[2] <= i_cfg_data;
                CFG_KEY3: r_key[3] <= i_cfg_data;
                default:  r_key[0] <= r_key[0];
            endcase
        end
    end

    fbcks_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .o_valid(o_valid), .i_stall(i_stall), .i_sts(w_sts), .o_cmd(w_cmd)
    );

    fbcks_dp #(.ROUND_COUNT(ROUND_COUNT)) u_dp (
        .i_clk(i_clk), .i_cmd(w_cmd), .o_sts(w_sts),
        .i_key({r_key[0], r_key[1], r_key[2], r_key[3]}),
        .i_op(i_op), .i_block(i_block_in), .o_block(o_block_out)
    );
endmodule
`default_nettype wire
